/* rtl/tgt_pkg.sv */
package tgt_pkg;

   localparam int GAIN_BITS  = 32;
   localparam int STEP_BITS  = 32;
   localparam int TOTAL_BITS = 48;
   localparam int MEAN_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int K_BITS     = 17;
   localparam int GAIN_COUNT = 3;
   localparam int IDX_BITS   = 2;

   localparam logic [STEP_BITS-1:0] ONE_Q16  = STEP_BITS'(65536);
   localparam logic [K_BITS-1:0]    K_GROW   = K_BITS'(72090);
   localparam logic [K_BITS-1:0]    K_SHRINK = K_BITS'(58982);

   // commands
   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_GAIN_P    = 2'd0;
   localparam logic [1:0] CSR_GAIN_I    = 2'd1;
   localparam logic [1:0] CSR_GAIN_D    = 2'd2;
   localparam logic [1:0] CSR_TOLERANCE = 2'd3;

   // tuning phases
   localparam logic [1:0] PH_PROBE = 2'd0;
   localparam logic [1:0] PH_INC   = 2'd1;
   localparam logic [1:0] PH_DEC   = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // gain plus step, or gain minus twice the step, saturated to signed 32 bits
   function automatic logic [GAIN_BITS-1:0] gain_move(input logic [GAIN_BITS-1:0] g,
                                                      input logic [STEP_BITS-1:0] s,
                                                      input logic sub_twice);
      logic [GAIN_BITS+1:0] ge;
      logic [GAIN_BITS+1:0] se;
      logic [GAIN_BITS+1:0] sum;
      ge  = {{2{g[GAIN_BITS-1]}}, g};
      se  = sub_twice ? {1'b0, s, 1'b0} : {2'b00, s};
      sum = sub_twice ? (ge - se) : (ge + se);
      if (sum[GAIN_BITS+1:GAIN_BITS-1] == 3'b000 || sum[GAIN_BITS+1:GAIN_BITS-1] == 3'b111) begin
         gain_move = sum[GAIN_BITS-1:0];
      end else if (sum[GAIN_BITS+1]) begin
         gain_move = {1'b1, {(GAIN_BITS-1){1'b0}}};
      end else begin
         gain_move = {1'b0, {(GAIN_BITS-1){1'b1}}};
      end
   endfunction

endpackage

/* rtl/tgt_if.sv */
interface tgt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] error_sample;

   modport source (output valid, output cmd, output error_sample, input ready);
   modport sink (input valid, input cmd, input error_sample, output ready);
endinterface

interface tgt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] gain_p;
   logic [31:0] gain_i;
   logic [31:0] gain_d;
   logic        tuning_done;
   logic        empty_run;

   modport source (output valid, output gain_p, output gain_i, output gain_d,
                   output tuning_done, output empty_run, input ready);
   modport sink (input valid, input gain_p, input gain_i, input gain_d,
                 input tuning_done, input empty_run, output ready);
endinterface

interface tgt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tgt_div.sv */
module tgt_div import tgt_pkg::*; #(
   parameter int DEN_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TOTAL_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0]   divisor,
   output unit_stat_type         stat,
   output logic [MEAN_BITS-1:0]  quotient
);

   localparam int CNT_BITS = $clog2(TOTAL_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;

   logic [DEN_BITS:0] trial;
   logic [DEN_BITS:0] diff;
   logic              fits;

   // one quotient bit a cycle, restoring
   assign trial = {rem_ff, quo_ff[TOTAL_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(TOTAL_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TOTAL_BITS-2:0], fits};
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // mean saturates to 32 bits
   assign quotient  = (|quo_ff[TOTAL_BITS-1:MEAN_BITS]) ? '1 : quo_ff[MEAN_BITS-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/tgt_mul.sv */
module tgt_mul import tgt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 grow,
   input  logic [STEP_BITS-1:0] step,
   output unit_stat_type        stat,
   output logic [STEP_BITS-1:0] result
);

   localparam int PROD_BITS = STEP_BITS + K_BITS;
   localparam int CNT_BITS  = $clog2(K_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [K_BITS-1:0]    k_ff, k_in;
   logic [STEP_BITS-1:0] s_ff, s_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;

   logic [PROD_BITS:0]   rnd;
   logic [PROD_BITS-FRAC_BITS:0] scaled;

   // shift-add, factor bits msb first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      s_in    = s_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(K_BITS - 1);
         k_in    = grow ? K_GROW : K_SHRINK;
         s_in    = step;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_BITS-2:0], 1'b0}
                + (k_ff[K_BITS-1] ? {{K_BITS{1'b0}}, s_ff} : '0);
         k_in   = {k_ff[K_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      k_ff   <= k_in;
      s_ff   <= s_in;
      acc_ff <= acc_in;
   end

   // round half up, drop the fraction, saturate
   assign rnd    = {1'b0, acc_ff} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
   assign scaled = rnd[PROD_BITS:FRAC_BITS];
   assign result = (|scaled[PROD_BITS-FRAC_BITS:STEP_BITS]) ? '1 : scaled[STEP_BITS-1:0];

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/twiddle_gain_tuner_top.sv */
// twiddle tuner for three pid gains, all values signed or unsigned q16.16
// req_if: one beat per command. sample (cmd 0) folds |error_sample| into the
//   running total and count. update (cmd 1) runs one tuning step
//   and yields one rsp beat. restart (cmd 2) reloads the gains from the csr
//   registers and yields nothing. cmd 3 is dropped.
// rsp_if: one beat per update with the three gains, tuning_done and empty_run.
// csr_if: always ready; index 0..2 are the starting gains, 3 the step
//   tolerance. write only while no update is in flight.
// throughput: samples and restarts leave req_if.ready high. an update keeps
//   req_if.ready low while it runs, which includes the bit-serial 48-bit
//   divide of the total (not when tuning is done or on an empty run) and
//   the bit-serial step scaling (only when a step is grown or shrunk).
// reset: csr registers clear, gains go to zero, steps and best error to 1.0,
//   total, count, phase and gain index to zero.
// stall: the result sits in an output register; samples keep being accepted
//   while it waits. a following update finishes its work and then holds in
//   its last state until the previous beat is taken.
module twiddle_gain_tuner_top import tgt_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   tgt_req_if.sink  req_if,
   tgt_rsp_if.source rsp_if,
   tgt_csr_if.sink  csr_if
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;  // takes commands
   localparam logic [2:0] ST_DIV  = 3'd1;  // waits for the mean error
   localparam logic [2:0] ST_TUNE = 3'd2;  // one twiddle decision
   localparam logic [2:0] ST_MUL  = 3'd3;  // waits for the scaled step
   localparam logic [2:0] ST_NEXT = 3'd4;  // probe the next gain
   localparam logic [2:0] ST_OUT  = 3'd5;  // hand the result to the output reg

   // csr registers
   logic [GAIN_BITS-1:0] init_gain_ff [GAIN_COUNT];
   logic [STEP_BITS-1:0] tolerance_ff;

   // tuner state
   logic [2:0]            state_ff, state_in;
   logic [GAIN_BITS-1:0]  gains_ff [GAIN_COUNT];
   logic [GAIN_BITS-1:0]  gains_in [GAIN_COUNT];
   logic [STEP_BITS-1:0]  steps_ff [GAIN_COUNT];
   logic [STEP_BITS-1:0]  steps_in [GAIN_COUNT];
   logic [MEAN_BITS-1:0]  best_ff, best_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [1:0]            phase_ff, phase_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [MEAN_BITS-1:0]  err_ff, err_in;
   logic                  done_ff, done_in;
   logic                  empty_ff, empty_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GAIN_BITS-1:0] rsp_gain_ff [GAIN_COUNT];
   logic                 rsp_done_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_load;

   // serial units
   logic                 div_start;
   unit_stat_type        div_stat;
   logic [MEAN_BITS-1:0] div_mean;
   logic                 mul_start;
   logic                 mul_grow;
   unit_stat_type        mul_stat;
   logic [STEP_BITS-1:0] mul_step;

   logic                  req_beat;
   logic [STEP_BITS-1:0]  abs_err;
   logic [TOTAL_BITS:0]   total_sum;
   logic [STEP_BITS+1:0]  step_sum;
   logic                  tune_done;
   logic [IDX_BITS-1:0]   ix;
   logic [IDX_BITS-1:0]   ix_next;
   logic                  better;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_beat     = req_if.valid && req_if.ready;

   // csr writes always land
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GAIN_COUNT; g++) begin
            init_gain_ff[g] <= '0;
         end
         tolerance_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_GAIN_P:    init_gain_ff[0] <= csr_if.data;
            CSR_GAIN_I:    init_gain_ff[1] <= csr_if.data;
            CSR_GAIN_D:    init_gain_ff[2] <= csr_if.data;
            CSR_TOLERANCE: tolerance_ff    <= csr_if.data;
            default: ;
         endcase
      end
   end

   // |sample|; the most negative value maps to 2^31, still fits unsigned
   assign abs_err   = req_if.error_sample[31] ? (~req_if.error_sample + 1'b1)
                                              : req_if.error_sample;
   assign total_sum = {1'b0, total_ff} + {{(TOTAL_BITS+1-STEP_BITS){1'b0}}, abs_err};

   assign step_sum  = {2'b00, steps_ff[0]} + {2'b00, steps_ff[1]} + {2'b00, steps_ff[2]};
   assign tune_done = !(step_sum > {2'b00, tolerance_ff});

   // an out-of-range gain index acts as the first gain
   assign ix      = (idx_ff > IDX_BITS'(GAIN_COUNT - 1)) ? '0 : idx_ff;
   assign ix_next = (ix == IDX_BITS'(GAIN_COUNT - 1)) ? '0 : ix + 1'b1;
   assign better  = (err_ff < best_ff);

   always_comb begin
      state_in  = state_ff;
      gains_in  = gains_ff;
      steps_in  = steps_ff;
      best_in   = best_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      empty_in  = empty_ff;
      div_start = 1'b0;
      mul_start = 1'b0;
      mul_grow  = 1'b0;
      rsp_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               case (req_if.cmd)
                  CMD_SAMPLE: begin
                     // a full count drops the sample
                     if (count_ff != '1) begin
                        total_in = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_UPDATE: begin
                     empty_in = (count_ff == '0);
                     done_in  = tune_done;
                     total_in = '0;
                     count_in = '0;
                     if (tune_done) begin
                        state_in = ST_OUT;
                     end else if (count_ff == '0) begin
                        // empty run counts as the worst error
                        err_in   = '1;
                        state_in = ST_TUNE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  CMD_RESTART: begin
                     for (int g = 0; g < GAIN_COUNT; g++) begin
                        gains_in[g] = init_gain_ff[g];
                        steps_in[g] = ONE_Q16;
                     end
                     best_in  = ONE_Q16;
                     total_in = '0;
                     count_in = '0;
                     phase_in = PH_PROBE;
                     idx_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               err_in   = div_mean;
               state_in = ST_TUNE;
            end
         end
         ST_TUNE: begin
            idx_in = ix;
            case (phase_ff)
               PH_INC: begin
                  if (better) begin
                     best_in   = err_ff;
                     mul_start = 1'b1;
                     mul_grow  = 1'b1;
                     state_in  = ST_MUL;
                  end else begin
                     gains_in[ix] = gain_move(gains_ff[ix], steps_ff[ix], 1'b1);
                     phase_in     = PH_DEC;
                     state_in     = ST_OUT;
                  end
               end
               PH_DEC: begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
                  if (better) begin
                     best_in  = err_ff;
                     mul_grow = 1'b1;
                  end else begin
                     // restore the gain, then shrink its step
                     gains_in[ix] = gain_move(gains_ff[ix], steps_ff[ix], 1'b0);
                  end
               end
               default: begin
                  // probe, and the unused phase code
                  gains_in[ix] = gain_move(gains_ff[ix], steps_ff[ix], 1'b0);
                  phase_in     = PH_INC;
                  state_in     = ST_OUT;
               end
            endcase
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               steps_in[idx_ff] = mul_step;
               idx_in           = ix_next;
               state_in         = ST_NEXT;
            end
         end
         ST_NEXT: begin
            gains_in[idx_ff] = gain_move(gains_ff[idx_ff], steps_ff[idx_ff], 1'b0);
            phase_in         = PH_INC;
            state_in         = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int g = 0; g < GAIN_COUNT; g++) begin
            gains_ff[g] <= '0;
            steps_ff[g] <= ONE_Q16;
         end
         best_ff  <= ONE_Q16;
         total_ff <= '0;
         count_ff <= '0;
         phase_ff <= PH_PROBE;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gains_ff <= gains_in;
         steps_ff <= steps_in;
         best_ff  <= best_in;
         total_ff <= total_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
         empty_ff <= empty_in;
      end
      err_ff <= err_in;
   end

   // output register: a new beat may load as the old one leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_gain_ff  <= gains_ff;
         rsp_done_ff  <= done_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.gain_p      = rsp_gain_ff[0];
   assign rsp_if.gain_i      = rsp_gain_ff[1];
   assign rsp_if.gain_d      = rsp_gain_ff[2];
   assign rsp_if.tuning_done = rsp_done_ff;
   assign rsp_if.empty_run   = rsp_empty_ff;

   // mean error = total / count, one quotient bit a cycle
   tgt_div #(
      .DEN_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (div_mean)
   );

   // step times 1.1 or 0.9, one factor bit a cycle
   tgt_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .grow   (mul_grow),
      .step   (steps_ff[ix]),
      .stat   (mul_stat),
      .result (mul_step)
   );

endmodule
